// File: sv/gts_pkg.sv
// shared types and constants for the grid tile sparse set
`default_nettype none

package gts_pkg;

  // field widths fixed by the interface
  localparam int ACT_W   = 2;
  localparam int COORD_W = 8;
  localparam int AREA_W  = 8;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // width used to compare a coordinate against the saturated map size
  localparam int LIM_W = 9;

  // default sizes
  localparam int DEF_MAX_SIDE  = 64;
  localparam int DEF_MAX_TILES = 4096;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // map size after reset
  localparam logic [CFG_W-1:0] MAP_SIZE_RESET = CFG_W'(64);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  // action codes on the input port
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

  // classified command kind
  typedef enum logic [1:0] {
    CLS_FAIL   = 2'd0,
    CLS_ADD    = 2'd1,
    CLS_REMOVE = 2'd2,
    CLS_LOOKUP = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [AREA_W-1:0]  area;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/grid_tile_sparse_set.sv
// top level of the grid tile sparse set
//
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    action, x, y, area_id
// out       out  out_valid/out_ready  ok, found_area, tile_count
// cfg       in   cfg_we               cfg_index, cfg_data (no read-back)
//
// sequencer states per beat: idle and done for a beat out of range or with
// an unknown action; idle, grid, look and done for a lookup that hits;
// idle, grid, move and done for a remove that moves the last entry; idle,
// grid and done for every other beat; a beat is registered in the queue
// before the sequencer takes it
// reset and every map size write start a clearing pass over the grid's
// MAX_SIDE*MAX_SIDE cells (4096 by default), with in_ready low
// a two-beat queue parts the front from the sequencer; a held result in the
// output register stalls only the sequencer's final step
`default_nettype none

module grid_tile_sparse_set #(
  parameter int MAX_SIDE  = gts_pkg::DEF_MAX_SIDE,
  parameter int MAX_TILES = gts_pkg::DEF_MAX_TILES
) (
  input  logic                                clk,
  input  logic                                rst,
  // item input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gts_pkg::ACT_W-1:0]           action,
  input  logic signed [gts_pkg::COORD_W-1:0]  x,
  input  logic signed [gts_pkg::COORD_W-1:0]  y,
  input  logic [gts_pkg::AREA_W-1:0]          area_id,
  // result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic [gts_pkg::AREA_W-1:0]          found_area,
  output logic [$clog2(MAX_TILES+1)-1:0]      tile_count,
  // configuration
  input  logic                                cfg_we,
  input  logic [gts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gts_pkg::CFG_W-1:0]           cfg_data
);
  import gts_pkg::*;

  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;
  logic             clear_req;
  logic             clearing;

  logic             fq_valid;
  logic             fq_ready;
  cmd_t             fq_data;
  logic             qb_valid;
  logic             qb_ready;
  cmd_t             qb_data;

  // any write to a map size empties the grid
  assign clear_req = cfg_we && (cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_SIZE_RESET;
      map_height <= MAP_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: range check and action decode
  gts_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .x          (x),
    .y          (y),
    .area_id    (area_id),
    .map_width  (map_width),
    .map_height (map_height),
    .clearing   (clearing),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_data     (fq_data)
  );

  // classified commands wait here for the sequencer
  gts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // back: memories, swap-remove sequencing, result register
  gts_back #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_TILES (MAX_TILES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .clear_req  (clear_req),
    .clearing   (clearing),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .found_area (found_area),
    .tile_count (tile_count)
  );

endmodule

`default_nettype wire

// File: sv/gts_front.sv
// front end: range check and classification of incoming beats
`default_nettype none

module gts_front #(
  parameter int MAX_SIDE = gts_pkg::DEF_MAX_SIDE
) (
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gts_pkg::ACT_W-1:0]          action,
  input  logic signed [gts_pkg::COORD_W-1:0] x,
  input  logic signed [gts_pkg::COORD_W-1:0] y,
  input  logic [gts_pkg::AREA_W-1:0]         area_id,
  input  logic [gts_pkg::CFG_W-1:0]          map_width,
  input  logic [gts_pkg::CFG_W-1:0]          map_height,
  input  logic                               clearing,
  output logic                               q_valid,
  input  logic                               q_ready,
  output gts_pkg::cmd_t                      q_data
);
  import gts_pkg::*;

  localparam logic [LIM_W-1:0] SIDE_LIM = LIM_W'(MAX_SIDE);

  logic [LIM_W-1:0] w_use;
  logic [LIM_W-1:0] h_use;
  logic             x_ok;
  logic             y_ok;
  cls_t             cls;

  // sizes above the grid saturate
  assign w_use = (LIM_W'(map_width) > SIDE_LIM) ? SIDE_LIM : LIM_W'(map_width);
  assign h_use = (LIM_W'(map_height) > SIDE_LIM) ? SIDE_LIM : LIM_W'(map_height);

  assign x_ok = !x[COORD_W-1] && (LIM_W'(x[COORD_W-2:0]) < w_use);
  assign y_ok = !y[COORD_W-1] && (LIM_W'(y[COORD_W-2:0]) < h_use);

  always_comb begin
    cls = CLS_FAIL;
    if (x_ok && y_ok) begin
      case (action)
        ACT_ADD:    cls = CLS_ADD;
        ACT_REMOVE: cls = CLS_REMOVE;
        ACT_LOOKUP: cls = CLS_LOOKUP;
        default:    cls = CLS_FAIL;
      endcase
    end
  end

  assign in_ready    = q_ready && !clearing;
  assign q_valid     = in_valid && !clearing;
  assign q_data.cls  = cls;
  assign q_data.x    = x;
  assign q_data.y    = y;
  assign q_data.area = area_id;

endmodule

`default_nettype wire

// File: sv/gts_queue.sv
// short command queue between front and back
`default_nettype none

module gts_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  gts_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output gts_pkg::cmd_t rd_data
);
  import gts_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gts_back.sv
// back end: grid and tile table memories, command sequencer, result register
`default_nettype none

module gts_back #(
  parameter int MAX_SIDE  = gts_pkg::DEF_MAX_SIDE,
  parameter int MAX_TILES = gts_pkg::DEF_MAX_TILES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear_req,
  output logic                             clearing,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  gts_pkg::cmd_t                    q_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             ok,
  output logic [gts_pkg::AREA_W-1:0]       found_area,
  output logic [$clog2(MAX_TILES+1)-1:0]   tile_count
);
  import gts_pkg::*;

  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int GRID_CELLS = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W     = $clog2(GRID_CELLS);
  localparam int IDX_W      = $clog2(MAX_TILES);
  localparam int CNT_W      = $clog2(MAX_TILES + 1);
  localparam int GE_W       = IDX_W + 1;
  localparam int TE_W       = 2 * SIDE_W + AREA_W;
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(GRID_CELLS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_GRID  = 6'b000100,
    S_LOOK  = 6'b001000,
    S_MOVE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  function automatic logic [CELL_W-1:0] cell_of(input logic [SIDE_W-1:0] cx,
                                                 input logic [SIDE_W-1:0] cy);
    return CELL_W'(CELL_W'(cy) * CELL_W'(MAX_SIDE)) + CELL_W'(cx);
  endfunction

  // grid: valid bit over a table index
  logic [GE_W-1:0] grid_mem [GRID_CELLS];
  logic [GE_W-1:0] grid_q;
  logic            g_we;
  logic [CELL_W-1:0] g_waddr;
  logic [GE_W-1:0] g_wdata;
  logic [CELL_W-1:0] g_raddr;

  // tile table: x, y, area
  logic [TE_W-1:0] tab_mem [MAX_TILES];
  logic [TE_W-1:0] tab_q;
  logic            t_we;
  logic [IDX_W-1:0] t_waddr;
  logic [TE_W-1:0] t_wdata;
  logic [IDX_W-1:0] t_raddr;

  state_t            state;
  logic [CELL_W-1:0] clr_cnt;
  logic [CNT_W-1:0]  total;
  cmd_t              cmd;
  logic [CELL_W-1:0] cmd_cell;
  logic [IDX_W-1:0]  slot;
  logic              res_ok;
  logic [AREA_W-1:0] res_found;

  logic              g_valid;
  logic [IDX_W-1:0]  g_idx;
  logic [CNT_W-1:0]  last;
  logic [IDX_W-1:0]  last_idx;
  logic              add_ok;
  logic              rem_ok;
  logic              moving;
  logic [CELL_W-1:0] mv_cell;
  logic              out_load;

  assign g_valid  = grid_q[GE_W-1];
  assign g_idx    = grid_q[IDX_W-1:0];
  assign last     = total - CNT_W'(1);
  assign last_idx = last[IDX_W-1:0];
  assign add_ok   = !g_valid && (total < CNT_W'(MAX_TILES));
  assign rem_ok   = g_valid && (total != '0);
  assign moving   = (g_idx != last_idx);
  assign mv_cell  = cell_of(tab_q[TE_W-1 -: SIDE_W], tab_q[AREA_W +: SIDE_W]);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign clearing = (state == S_CLEAR);
  assign q_ready  = (state == S_IDLE);
  assign g_raddr  = cell_of(q_data.x[SIDE_W-1:0], q_data.y[SIDE_W-1:0]);
  assign t_raddr  = (cmd.cls == CLS_LOOKUP) ? g_idx : last_idx;

  // memory write ports
  always_comb begin
    g_we    = 1'b0;
    g_waddr = cmd_cell;
    g_wdata = '0;
    t_we    = 1'b0;
    t_waddr = total[IDX_W-1:0];
    t_wdata = {cmd.x[SIDE_W-1:0], cmd.y[SIDE_W-1:0], cmd.area};
    case (state)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_cnt;
      end
      S_GRID: begin
        if (cmd.cls == CLS_ADD && add_ok) begin
          g_we    = 1'b1;
          g_wdata = {1'b1, total[IDX_W-1:0]};
          t_we    = 1'b1;
        end else if (cmd.cls == CLS_REMOVE && rem_ok) begin
          g_we = 1'b1;
        end
      end
      S_MOVE: begin
        g_we    = 1'b1;
        g_waddr = mv_cell;
        g_wdata = {1'b1, slot};
        t_we    = 1'b1;
        t_waddr = slot;
        t_wdata = tab_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    grid_q <= grid_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tab_mem[t_waddr] <= t_wdata;
    end
    tab_q <= tab_mem[t_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cmd      <= q_data;
      cmd_cell <= g_raddr;
    end
    if (state == S_GRID) begin
      slot <= g_idx;
    end
    if (out_load) begin
      ok         <= res_ok;
      found_area <= res_found;
      tile_count <= total;
    end
  end

  // result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst || clear_req) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      total   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CELL_W'(1);
          if (clr_cnt == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            res_ok    <= 1'b0;
            res_found <= '0;
            state     <= (q_data.cls == CLS_FAIL) ? S_DONE : S_GRID;
          end
        end
        S_GRID: begin
          case (cmd.cls)
            CLS_ADD: begin
              state <= S_DONE;
              if (add_ok) begin
                total  <= total + CNT_W'(1);
                res_ok <= 1'b1;
              end
            end
            CLS_LOOKUP: begin
              state <= g_valid ? S_LOOK : S_DONE;
            end
            CLS_REMOVE: begin
              if (rem_ok && moving) begin
                state <= S_MOVE;
              end else begin
                state <= S_DONE;
                if (rem_ok) begin
                  total  <= last;
                  res_ok <= 1'b1;
                end
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_LOOK: begin
          res_found <= tab_q[AREA_W-1:0];
          res_ok    <= 1'b1;
          state     <= S_DONE;
        end
        S_MOVE: begin
          total  <= last;
          res_ok <= 1'b1;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/gts_tb_pkg.sv
// scoreboard for the grid tile sparse set: cell grid, dense tile table and result queue
`timescale 1ns / 1ps

package gts_tb_pkg;

  localparam int SIDE   = gts_pkg::DEF_MAX_SIDE;
  localparam int TILES  = gts_pkg::DEF_MAX_TILES;
  localparam int CELLS  = SIDE * SIDE;
  localparam int CNT_W  = $clog2(TILES + 1);
  localparam int REPORT_LIMIT = 10;

  // action code the block must treat as a no-op
  localparam logic [gts_pkg::ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                       ok;
    logic [gts_pkg::AREA_W-1:0] area;
    logic [CNT_W-1:0]           count;
  } tile_result_t;

  class tile_set_scoreboard;
    // cell grid: occupancy plus slot in the tile table
    bit                         occupied [CELLS];
    int                         slot_of  [CELLS];
    // dense tile table
    logic [7:0]                 tile_x    [TILES];
    logic [7:0]                 tile_y    [TILES];
    logic [7:0]                 tile_area [TILES];
    int                         total;
    logic [gts_pkg::CFG_W-1:0]  width_reg;
    logic [gts_pkg::CFG_W-1:0]  height_reg;
    tile_result_t               expected_results [$];
    // bookkeeping
    int accepted, checked, failures;
    int adds_done, removes_done, moves_done, lookups_hit;

    function new();
      width_reg  = gts_pkg::MAP_SIZE_RESET;
      height_reg = gts_pkg::MAP_SIZE_RESET;
      clear_tiles();
    endfunction

    function void clear_tiles();
      for (int i = 0; i < CELLS; i++) begin
        occupied[i] = 1'b0;
        slot_of[i]  = 0;
      end
      total = 0;
    endfunction

    // any size write empties the grid
    function void set_size(logic [gts_pkg::CFG_IDX_W-1:0] idx,
                           logic [gts_pkg::CFG_W-1:0] val);
      if (idx == gts_pkg::REG_MAP_WIDTH) width_reg = val;
      else height_reg = val;
      clear_tiles();
    endfunction

    function int side_in_use(logic [gts_pkg::CFG_W-1:0] reg_val);
      return (int'(reg_val) > SIDE) ? SIDE : int'(reg_val);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_beat(logic [gts_pkg::ACT_W-1:0] act, logic [7:0] xr,
                            logic [7:0] yr, logic [7:0] area);
      tile_result_t res;
      int cell_idx, slot, last, moved_cell;
      res = '0;
      accepted++;
      if (!xr[7] && int'(xr) < side_in_use(width_reg) &&
          !yr[7] && int'(yr) < side_in_use(height_reg)) begin
        cell_idx = int'(yr) * SIDE + int'(xr);
        case (act)
          gts_pkg::ACT_ADD: begin
            if (!occupied[cell_idx] && total < TILES) begin
              tile_x[total]      = xr;
              tile_y[total]      = yr;
              tile_area[total]   = area;
              slot_of[cell_idx]  = total;
              occupied[cell_idx] = 1'b1;
              total++;
              res.ok = 1'b1;
              adds_done++;
            end
          end
          gts_pkg::ACT_REMOVE: begin
            if (occupied[cell_idx] && total > 0) begin
              slot = slot_of[cell_idx];
              last = total - 1;
              occupied[cell_idx] = 1'b0;
              if (slot != last) begin
                // last entry fills the hole, its cell follows it
                moved_cell = int'(tile_y[last]) * SIDE + int'(tile_x[last]);
                slot_of[moved_cell] = slot;
                tile_x[slot]    = tile_x[last];
                tile_y[slot]    = tile_y[last];
                tile_area[slot] = tile_area[last];
                moves_done++;
              end
              total = last;
              res.ok = 1'b1;
              removes_done++;
            end
          end
          gts_pkg::ACT_LOOKUP: begin
            if (occupied[cell_idx]) begin
              res.ok   = 1'b1;
              res.area = tile_area[slot_of[cell_idx]];
              lookups_hit++;
            end
          end
          default: ;
        endcase
      end
      res.count = CNT_W'(total);
      expected_results = {expected_results, res};
    endfunction

    function void check_beat(logic ok_bit, logic [7:0] area, logic [CNT_W-1:0] count);
      tile_result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result beat: ok=%0d area=%0d count=%0d", ok_bit, area, count);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (want.ok !== ok_bit || want.area !== area || want.count !== count) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display({"mismatch on result %0d: expected ok=%0d area=%0d count=%0d,",
                    " got ok=%0d area=%0d count=%0d"},
                   checked, want.ok, want.area, want.count, ok_bit, area, count);
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// top-level testbench for the grid tile sparse set
`timescale 1ns / 1ps

module tb_top;
  import gts_tb_pkg::*;

  // generous cycle budget: clearing passes dominate, then worst-case gaps per beat
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [gts_pkg::ACT_W-1:0]         action;
  logic signed [gts_pkg::COORD_W-1:0] x;
  logic signed [gts_pkg::COORD_W-1:0] y;
  logic [gts_pkg::AREA_W-1:0]        area_id;
  logic                              out_valid;
  logic                              out_ready;
  logic                              ok;
  logic [gts_pkg::AREA_W-1:0]        found_area;
  logic [CNT_W-1:0]                  tile_count;
  logic                              cfg_we;
  logic [gts_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [gts_pkg::CFG_W-1:0]         cfg_data;

  tile_set_scoreboard sb;
  bit burst;      // when set, neither side idles
  int cycles;

  // map sizes stepped through after the reset size, and random beats per size;
  // covers size one, zero on either axis, and values above the largest side
  int phase_w     [PHASES] = '{4, 1, 127, 0, 9, 8, 65, 2};
  int phase_h     [PHASES] = '{4, 1, 6, 5, 0, 8, 64, 127};
  int phase_beats [PHASES] = '{180, 60, 150, 50, 40, 250, 250, 120};

  grid_tile_sparse_set uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .x          (x),
    .y          (y),
    .area_id    (area_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .found_area (found_area),
    .tile_count (tile_count),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result monitor: sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_beat(ok, found_area, tile_count);
  end

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // coordinate for a random beat: mostly in range, the rest negative,
  // just past the edge, or any 8-bit value
  function automatic logic [7:0] pick_coord(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim > 0 && r < 85) return 8'($urandom_range(0, lim - 1));
    if (r < 90) return 8'($urandom_range(128, 255));
    if (r < 95) return 8'(lim + $urandom_range(0, 1));
    return 8'($urandom);
  endfunction

  // one input beat: optional idle gap, then hold valid until accepted;
  // valid is left high so a back-to-back beat never toggles it in one step
  task automatic send_beat(logic [gts_pkg::ACT_W-1:0] act, logic [7:0] xc,
                           logic [7:0] yc, logic [7:0] area);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    x        <= xc;
    y        <= yc;
    area_id  <= area;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(act, xc, yc, area);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // size write; the block then clears the grid with in_ready low
  task automatic write_size(logic [gts_pkg::CFG_IDX_W-1:0] idx,
                            logic [gts_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_size(idx, val);
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // resize only once the block has drained
  task automatic apply_sizes(int w, int h);
    idle_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_size(gts_pkg::REG_MAP_WIDTH, gts_pkg::CFG_W'(w));
    write_size(gts_pkg::REG_MAP_HEIGHT, gts_pkg::CFG_W'(h));
  endtask

  // directed beats on the reset 64 x 64 map
  task automatic directed_beats();
    send_beat(gts_pkg::ACT_LOOKUP, 8'd0, 8'd0, 8'd0);     // lookup of an empty cell
    send_beat(gts_pkg::ACT_REMOVE, 8'd0, 8'd0, 8'd0);     // remove of an empty cell
    send_beat(gts_pkg::ACT_ADD, 8'd0, 8'd0, 8'hFF);
    send_beat(gts_pkg::ACT_ADD, 8'd63, 8'd63, 8'h00);     // far corner
    send_beat(gts_pkg::ACT_ADD, 8'd63, 8'd0, 8'hA5);
    send_beat(gts_pkg::ACT_ADD, 8'd0, 8'd0, 8'h11);       // occupied cell
    send_beat(gts_pkg::ACT_LOOKUP, 8'd0, 8'd0, 8'h00);
    send_beat(gts_pkg::ACT_LOOKUP, 8'd63, 8'd63, 8'h7E);
    send_beat(gts_pkg::ACT_ADD, 8'd64, 8'd0, 8'h01);      // x at the width
    send_beat(gts_pkg::ACT_ADD, 8'd0, 8'd64, 8'h01);      // y at the height
    send_beat(gts_pkg::ACT_ADD, 8'hFF, 8'd1, 8'h01);      // x = -1
    send_beat(gts_pkg::ACT_ADD, 8'h80, 8'd0, 8'h01);      // x = -128
    send_beat(gts_pkg::ACT_ADD, 8'h7F, 8'h7F, 8'h01);     // both at +127
    send_beat(gts_pkg::ACT_LOOKUP, 8'd0, 8'h80, 8'h00);   // y = -128
    send_beat(ACT_UNKNOWN, 8'd0, 8'd0, 8'h33);            // unknown action on a held cell
    send_beat(gts_pkg::ACT_REMOVE, 8'd0, 8'd0, 8'h00);    // first slot, last entry moves in
    send_beat(gts_pkg::ACT_LOOKUP, 8'd63, 8'd0, 8'h00);   // moved entry still found
    send_beat(gts_pkg::ACT_REMOVE, 8'd63, 8'd0, 8'h00);
    send_beat(gts_pkg::ACT_REMOVE, 8'd63, 8'd63, 8'h00);  // removes the last entry
    send_beat(gts_pkg::ACT_REMOVE, 8'd63, 8'd63, 8'h00);  // already gone
    send_beat(gts_pkg::ACT_ADD, 8'd5, 8'd7, 8'h5A);
    send_beat(gts_pkg::ACT_REMOVE, 8'd5, 8'd7, 8'h00);    // sole entry, nothing moves
    send_beat(gts_pkg::ACT_LOOKUP, 8'd5, 8'd7, 8'h00);
  endtask

  // random beats: add-heavy so the table grows, removes and lookups mostly
  // aimed at held tiles so swaps happen, plus out-of-range and unknown noise
  task automatic random_beats(int n);
    int r, slot;
    logic [gts_pkg::ACT_W-1:0] act;
    logic [7:0] xc, yc;
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) act = gts_pkg::ACT_ADD;
      else if (r < 75) act = gts_pkg::ACT_REMOVE;
      else if (r < 95) act = gts_pkg::ACT_LOOKUP;
      else act = ACT_UNKNOWN;
      if (act != gts_pkg::ACT_ADD && sb.total > 0 && $urandom_range(0, 9) < 7) begin
        slot = $urandom_range(0, sb.total - 1);
        xc = sb.tile_x[slot];
        yc = sb.tile_y[slot];
      end else begin
        xc = pick_coord(sb.side_in_use(sb.width_reg));
        yc = pick_coord(sb.side_in_use(sb.height_reg));
      end
      send_beat(act, xc, yc, 8'($urandom_range(0, 255)));
    end
  endtask

  // output side: random stall before each result, then wait for the beat
  initial begin
    int stall;
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (rst || !out_valid) @(posedge clk);
    end
  end

  // main sequence
  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = '0;
    x         = '0;
    y         = '0;
    area_id   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cycles    = 0;
    burst     = 1'b0;
    sb = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset size first; send_beat rides out the clearing pass on in_ready
    directed_beats();
    random_beats(150);
    for (int p = 0; p < PHASES; p++) begin
      apply_sizes(phase_w[p], phase_h[p]);
      random_beats(phase_beats[p]);
    end

    // drain, then give the sequencer time to emit anything stray
    idle_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d beats in, %0d results checked over %0d map sizes", sb.accepted, sb.checked,
             PHASES + 1);
    $display("adds %0d, removes %0d (%0d with a moved entry), lookup hits %0d",
             sb.adds_done, sb.removes_done, sb.moves_done, sb.lookups_hit);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", sb.failures);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
